FILE: hdl/bilinear_texture_sampler_macros.svh
// Assertion macros shared by the bilinear texture sampler RTL.
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bilinear sampler check failed");

// Next-cycle implication, disabled in reset.
`define BTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bilinear sampler check failed");

`endif

FILE: hdl/bts_pkg.sv
// Package with constants and codes of the bilinear texture sampler.
package bts_pkg;

    localparam int BTS_MAX_DIM     = 256;
    localparam int BTS_WEIGHT_BITS = 8;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;
    localparam int CFG_W     = 9;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

endpackage

FILE: hdl/bts_ram.sv
// Generic RAM: one write port, two registered read ports.
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: hdl/bilinear_texture_sampler.sv
// Top level: five-stage bilinear texture sampler with an RGB texel store.
//
// Input stream s_axis: tuser is the opcode. A write transfer (opcode 0) stores
// one RGB texel at (texel_x, texel_y) and gives no result. A sample transfer
// (opcode 1) gives one result transfer on m_axis with the three channels in
// 8.8 fixed point. Results leave in the order the samples came in.
// Configuration: i_cfg_we with i_cfg_idx 0 sets tex_width, 1 sets tex_height;
// write them only while no item is in flight. Zero is taken as 1, values
// above MAX_DIM as MAX_DIM.
// A sample passes the scale multiply, index clamp, store read, row blend and
// column blend stages, in that order, before it is shown on m_axis.
// Throughput: one item per cycle while m_axis does not stall; the store is
// held twice, one copy per texel row, each with two read ports, so all four
// texels are read in the same cycle. A write passes the stage 1 and stage 2
// registers and then reaches the store, before any later sample reads it.
// When m_axis stalls, stages fill up from the output back; s_axis_tready
// falls only when every stage holds an item. Nothing is lost or repeated.
// Reset clears all valid bits and sets both sizes to min(256, MAX_DIM); the
// texel store is not cleared and holds garbage until written.
module bilinear_texture_sampler #(
    parameter int MAX_DIM     = bts_pkg::BTS_MAX_DIM,
    parameter int WEIGHT_BITS = bts_pkg::BTS_WEIGHT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // texel_x[7:0], texel_y[15:8], texel_red[23:16], texel_green[31:24],
    // texel_blue[39:32], coord_u[56:40], coord_v[73:57], zero pad above
    input  logic [bts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,  // opcode
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_red[15:0], sample_green[31:16], sample_blue[47:32]
    output logic [bts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [bts_pkg::CFG_W-1:0]      i_cfg_data
);

    import bts_pkg::*;

    `include "bilinear_texture_sampler_macros.svh"

    localparam int W        = WEIGHT_BITS;
    localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SZ_W     = $clog2(MAX_DIM + 1);
    localparam int CW       = SZ_W + 1;
    localparam int PW       = 17 + SZ_W;
    localparam int AW       = 2 * DIM_W;
    localparam int DEPTH    = 1 << AW;
    localparam int WONE     = 1 << W;
    localparam int TW       = 8 + W;
    localparam int MW       = 8 + 2 * W;
    localparam int SIZE_RST = (MAX_DIM < 256) ? MAX_DIM : 256;
    localparam int TOP_MAX  = 255 * WONE;

    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
        logic [W-1:0]     wt;
    } t_loc;

    function automatic t_loc locate(input logic [PW-1:0] p, input logic [SZ_W-1:0] size);
        logic [CW-1:0] base;
        logic [CW-1:0] szm1;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        logic [W-1:0]  wt;
        t_loc          res;
        base = p[PW-1:16];
        szm1 = CW'(size) - CW'(1);
        wt   = p[15 -: W];
        lo   = base;
        // clamp the base at the far edge, coordinate 1.0 included
        if (base > szm1) begin
            lo = szm1;
            wt = '0;
        end
        hi     = ((lo + CW'(1)) < CW'(size)) ? lo + CW'(1) : szm1;
        res.lo = DIM_W'(lo);
        res.hi = DIM_W'(hi);
        res.wt = wt;
        return res;
    endfunction

    function automatic logic [SZ_W-1:0] fit_size(input logic [CFG_W-1:0] v);
        logic [SZ_W-1:0] res;
        if (v == '0) begin
            res = SZ_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = SZ_W'(MAX_DIM);
        end else begin
            res = SZ_W'(v);
        end
        return res;
    endfunction

    // configuration
    logic [SZ_W-1:0] r_width;
    logic [SZ_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SZ_W'(SIZE_RST);
            r_height <= SZ_W'(SIZE_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEX_WIDTH:  r_width  <= fit_size(i_cfg_data);
                CFG_TEX_HEIGHT: r_height <= fit_size(i_cfg_data);
                default:        r_width  <= r_width;
            endcase
        end
    end

    // stage enables, rippling back from the output
    logic en1, en2, en3, en4, en5;
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;

    assign en5 = !r5_vld || m_axis_tready;
    assign en4 = !r4_vld || en5;
    assign en3 = !r3_vld || en4;
    assign en2 = !r2_vld || en3;
    assign en1 = !r1_vld || en2;
    assign s_axis_tready = en1;

    // stage 1: scale coordinates, check write position
    logic            r1_op;
    logic [AW-1:0]   r1_waddr;
    logic            r1_wok;
    logic [23:0]     r1_rgb;
    logic [PW-1:0]   r1_pu;
    logic [PW-1:0]   r1_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en1) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op    <= s_axis_tuser;
            r1_waddr <= {DIM_W'(s_axis_tdata[15:8]), DIM_W'(s_axis_tdata[7:0])};
            r1_wok   <= (32'(s_axis_tdata[7:0]) < MAX_DIM)
                        && (32'(s_axis_tdata[15:8]) < MAX_DIM);
            // store layout: red high, blue low
            r1_rgb   <= {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
            r1_pu    <= PW'(s_axis_tdata[56:40]) * PW'(r_width);
            r1_pv    <= PW'(s_axis_tdata[73:57]) * PW'(r_height);
        end
    end

    // stage 2: integer and fraction parts, neighbour clamp
    logic          r2_op;
    logic [AW-1:0] r2_waddr;
    logic          r2_wok;
    logic [23:0]   r2_rgb;
    t_loc          r2_lx;
    t_loc          r2_ly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_op    <= r1_op;
            r2_waddr <= r1_waddr;
            r2_wok   <= r1_wok;
            r2_rgb   <= r1_rgb;
            r2_lx    <= locate(r1_pu, r_width);
            r2_ly    <= locate(r1_pv, r_height);
        end
    end

    // stage 3: store access; one copy per row so four texels read at once
    logic          ram_we;
    logic [23:0]   q_t0, q_t1, q_b0, q_b1;
    logic [W-1:0]  r3_tx;
    logic [W-1:0]  r3_ty;

    assign ram_we = en3 && r2_vld && (r2_op == OP_WRITE) && r2_wok;

    bts_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_top (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r2_waddr),
        .i_wdata   (r2_rgb),
        .i_re      (en3),
        .i_raddr_a ({r2_ly.lo, r2_lx.lo}),
        .i_raddr_b ({r2_ly.lo, r2_lx.hi}),
        .o_rdata_a (q_t0),
        .o_rdata_b (q_t1)
    );

    bts_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_bot (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r2_waddr),
        .i_wdata   (r2_rgb),
        .i_re      (en3),
        .i_raddr_a ({r2_ly.hi, r2_lx.lo}),
        .i_raddr_b ({r2_ly.hi, r2_lx.hi}),
        .o_rdata_a (q_b0),
        .o_rdata_b (q_b1)
    );

    // drop writes here: they give no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en3) begin
            r3_vld <= r2_vld && (r2_op == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_tx <= r2_lx.wt;
            r3_ty <= r2_ly.wt;
        end
    end

    // stage 4: blend along x
    logic [TW-1:0] n4_top [3];
    logic [TW-1:0] n4_bot [3];
    logic [TW-1:0] r4_top [3];
    logic [TW-1:0] r4_bot [3];
    logic [W-1:0]  r4_ty;

    always_comb begin
        logic [W:0] inv;
        inv = (W+1)'(WONE) - (W+1)'(r3_tx);
        for (int ch = 0; ch < 3; ch++) begin
            n4_top[ch] = TW'(q_t0[(2-ch)*8 +: 8]) * TW'(inv)
                       + TW'(q_t1[(2-ch)*8 +: 8]) * TW'(r3_tx);
            n4_bot[ch] = TW'(q_b0[(2-ch)*8 +: 8]) * TW'(inv)
                       + TW'(q_b1[(2-ch)*8 +: 8]) * TW'(r3_tx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en4) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_top <= n4_top;
            r4_bot <= n4_bot;
            r4_ty  <= r3_ty;
        end
    end

    // stage 5: blend along y, scale to 8.8
    logic [MW-1:0] n5_mix [3];
    logic [15:0]   r5_pix [3];

    always_comb begin
        logic [W:0] inv;
        inv = (W+1)'(WONE) - (W+1)'(r4_ty);
        for (int ch = 0; ch < 3; ch++) begin
            n5_mix[ch] = MW'(r4_top[ch]) * MW'(inv) + MW'(r4_bot[ch]) * MW'(r4_ty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en5) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int ch = 0; ch < 3; ch++) begin
                r5_pix[ch] <= n5_mix[ch][MW-1 -: 16];
            end
        end
    end

    assign m_axis_tvalid = r5_vld;
    assign m_axis_tdata  = {r5_pix[2], r5_pix[1], r5_pix[0]};

    `BTS_ASSERT_IMP(a_x_adjacent, r2_vld && (r2_op == OP_SAMPLE), (r2_lx.hi == r2_lx.lo) || (r2_lx.hi == r2_lx.lo + 1'b1))
    `BTS_ASSERT_IMP(a_y_adjacent, r2_vld && (r2_op == OP_SAMPLE), (r2_ly.hi == r2_ly.lo) || (r2_ly.hi == r2_ly.lo + 1'b1))
    `BTS_ASSERT_NXT(a_write_no_result, en3 && r2_vld && (r2_op == OP_WRITE), !r3_vld)
    `BTS_ASSERT_IMP(a_row_blend_range, r4_vld, (32'(r4_top[0]) <= TOP_MAX) && (32'(r4_bot[0]) <= TOP_MAX))

endmodule

FILE: sim/bts_checker.sv
// Checker for the bilinear texture sampler: predicts samples and compares results.
module bts_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [bts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bts_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    import bts_pkg::*;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_rgb_sample;

    logic [23:0] texels [0:65535];
    logic [8:0]  width_q;
    logic [8:0]  height_q;
    t_rgb_sample sample_q[$];
    int          errors = 0;

    function automatic logic [8:0] clamp_size(logic [8:0] v);
        if (v == 0) return 9'd1;
        if (v > BTS_MAX_DIM) return 9'(BTS_MAX_DIM);
        return v;
    endfunction

    // Scale a Q1.16 coordinate by the size and split it into base index, next index and weight.
    function automatic void split_coord(input logic [16:0] coord, input logic [8:0] size,
                                        output int lo, output int hi, output int wt);
        logic [33:0] p;
        p  = 34'(coord) * 34'(size);
        lo = int'(p >> 16);
        wt = int'(p[15:8]);
        if (lo > size - 1) begin
            lo = size - 1;
            wt = 0;
        end
        hi = (lo + 1 < size) ? lo + 1 : size - 1;
    endfunction

    function automatic t_rgb_sample blend(logic [16:0] u, logic [16:0] v);
        int x1, x2, y1, y2, tx, ty, sh;
        logic [23:0] c0, c1, c2, c3;
        longint a, b, d, e, top, bot, mix;
        logic [15:0] ch [3];
        split_coord(u, width_q, x1, x2, tx);
        split_coord(v, height_q, y1, y2, ty);
        c0 = texels[y1 * 256 + x1];
        c1 = texels[y1 * 256 + x2];
        c2 = texels[y2 * 256 + x1];
        c3 = texels[y2 * 256 + x2];
        for (int k = 0; k < 3; k++) begin
            sh  = 16 - 8 * k;
            a   = (c0 >> sh) & 8'hFF;
            b   = (c1 >> sh) & 8'hFF;
            d   = (c2 >> sh) & 8'hFF;
            e   = (c3 >> sh) & 8'hFF;
            top = a * (256 - tx) + b * tx;
            bot = d * (256 - tx) + e * tx;
            mix = top * (256 - ty) + bot * ty;
            ch[k] = 16'(mix >> 8);
        end
        return '{blue: ch[2], green: ch[1], red: ch[0]};
    endfunction

    task automatic report(string msg);
        $display("mismatch %s at %0t", msg, $time);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_rgb_sample want, got;
        if (!i_rst_n) begin
            width_q  <= 9'd256;
            height_q <= 9'd256;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TEX_WIDTH) width_q <= clamp_size(i_cfg_data);
                else height_q <= clamp_size(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // store layout: red high, blue low
                if (s_axis_tuser == OP_WRITE)
                    texels[s_axis_tdata[15:8] * 256 + s_axis_tdata[7:0]] =
                        {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
                else
                    sample_q.push_back(blend(s_axis_tdata[56:40], s_axis_tdata[73:57]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (sample_q.size() == 0) begin
                    report("result transfer with no sample waiting");
                end else begin
                    want = sample_q.pop_front();
                    if (got.red != want.red)
                        report($sformatf("red: expected %h got %h", want.red, got.red));
                    if (got.green != want.green)
                        report($sformatf("green: expected %h got %h", want.green, got.green));
                    if (got.blue != want.blue)
                        report($sformatf("blue: expected %h got %h", want.blue, got.blue));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= sample_q.size();
    end
endmodule

FILE: sim/tb_top.sv
// Testbench top: stimulus, handshake idling and verdict for the texture sampler.
module tb_top;
    import bts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = OP_WRITE;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = CFG_TEX_WIDTH;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  region_w = 256;
    int  region_h = 256;

    always #10 i_clk = ~i_clk;

    bilinear_texture_sampler i_dut (.*);

    bts_checker i_chk (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** bilinear_texture_sampler: FAILED **");
            $finish;
        end
    end

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send(logic op, logic [7:0] x, logic [7:0] y, logic [23:0] rgb,
                        logic [16:0] u, logic [16:0] v);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, v, u, rgb[7:0], rgb[15:8], rgb[23:16], y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic put_texel(int x, int y);
        send(OP_WRITE, 8'(x), 8'(y), 24'($urandom), 17'($urandom), 17'($urandom));
    endtask

    task automatic sample(logic [16:0] u, logic [16:0] v);
        send(OP_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), u, v);
    endtask

    function automatic logic [16:0] rand_coord();
        case ($urandom_range(0, 15))
            0: return 17'd0;
            1: return 17'd65536;
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    // Drain pending samples, then let writes settle before touching the sizes.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [8:0] w, logic [8:0] h);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TEX_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TEX_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        region_w = (w == 0) ? 1 : (w > 256) ? 256 : w;
        region_h = (h == 0) ? 1 : (h > 256) ? 256 : h;
    endtask

    // Receiver: random stalls per result, one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end
            gap = idle_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [8:0] w_list [9];
        logic [8:0] h_list [9];
        w_list = '{9'd0, 9'd511, 9'd1, 9'd2, 9'd5, 9'd0, 9'd0, 9'd0, 9'd0};
        h_list = '{9'd0, 9'd0, 9'd256, 9'd3, 9'd7, 9'd0, 9'd0, 9'd0, 9'd0};
        for (int k = 5; k < 9; k++) begin
            w_list[k] = 9'($urandom_range(1, 16));
            h_list[k] = 9'($urandom_range(1, 16));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset sizes, extreme colors, corners and the 1.0 clamp.
        send(OP_WRITE, 8'd0, 8'd0, 24'hFFFFFF, 17'd0, 17'd0);
        send(OP_WRITE, 8'd1, 8'd0, 24'h000000, 17'h1FFFF, 17'h1FFFF);
        send(OP_WRITE, 8'd0, 8'd1, 24'h00FF00, 17'd0, 17'd0);
        send(OP_WRITE, 8'd1, 8'd1, 24'hFF00FF, 17'd0, 17'd0);
        send(OP_WRITE, 8'd255, 8'd255, 24'h123456, 17'd0, 17'd0);
        send(OP_WRITE, 8'd255, 8'd0, 24'hA5A5A5, 17'd0, 17'd0);
        send(OP_WRITE, 8'd255, 8'd1, 24'h5A5A5A, 17'd0, 17'd0);
        sample(17'd0, 17'd0);
        sample(17'd65536, 17'd65536);
        sample(17'd128, 17'd128);
        sample(17'd255, 17'd1);
        sample(17'd65536, 17'd0);
        sample(17'd65536, 17'd200);

        for (int ph = 0; ph < 9; ph++) begin
            set_sizes(w_list[ph], h_list[ph]);
            no_idle = (ph == 2);
            for (int y = 0; y < region_h; y++)
                for (int x = 0; x < region_w; x++)
                    put_texel(x, y);
            sample(17'd0, 17'd0);
            sample(17'd65536, 17'd65536);
            for (int n = 0; n < 120; n++) begin
                if (ph == 3 && n == 10) hold_req = 1;
                if (ph == 2 && n == 60) no_idle = 0;
                case ($urandom_range(0, 9))
                    0, 1: put_texel($urandom_range(0, region_w - 1),
                                    $urandom_range(0, region_h - 1));
                    2: put_texel($urandom_range(0, 255), $urandom_range(0, 255));
                    default: sample(rand_coord(), rand_coord());
                endcase
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("** bilinear_texture_sampler: PASSED **");
        else
            $display("** bilinear_texture_sampler: FAILED **");
        $finish;
    end
endmodule

FILE: bilinear_texture_sampler.f
+incdir+hdl
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bilinear_texture_sampler.sv
sim/bts_checker.sv
sim/tb_top.sv
